// ===== src/lu8dec_pkg.sv =====
// Package for the lenient UTF-8 decoder: job type between the front and back
// parts, byte class constants and the decode functions. No dependencies.
`default_nettype none

package lu8dec_pkg;

    localparam int CP_W = 21;

    // lead classification masks and patterns
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] MASK_2      = 8'hE0;
    localparam logic [7:0] LEAD_2      = 8'hC0;
    localparam logic [7:0] MASK_3      = 8'hF0;
    localparam logic [7:0] LEAD_3      = 8'hE0;
    localparam logic [7:0] MASK_4      = 8'hF8;
    localparam logic [7:0] LEAD_4      = 8'hF0;

    // announced sequence length codes
    localparam logic [2:0] LEN_BAD = 3'd0;
    localparam logic [2:0] LEN_1   = 3'd1;
    localparam logic [2:0] LEN_2   = 3'd2;
    localparam logic [2:0] LEN_3   = 3'd3;
    localparam logic [2:0] LEN_4   = 3'd4;

    typedef enum logic {
        JOB_CP,     // one ready code point
        JOB_FLUSH   // buffered bytes to re-decode at end of string
    } job_kind_t;

    typedef struct packed {
        job_kind_t          kind;
        logic [CP_W-1:0]    cp;
        logic [1:0]         n_bytes;
        logic [2:0][7:0]    bytes;
    } job_t;

    typedef struct packed {
        logic [1:0]              cnt;
        logic [2:0][CP_W-1:0]    cp;
    } run_t;

    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] len;
        if (b < ASCII_LIMIT)               len = LEN_1;
        else if ((b & MASK_2) == LEAD_2)   len = LEN_2;
        else if ((b & MASK_3) == LEAD_3)   len = LEN_3;
        else if ((b & MASK_4) == LEAD_4)   len = LEN_4;
        else                               len = LEN_BAD;
        return len;
    endfunction

    function automatic logic [CP_W-1:0] combine(
        input logic [2:0] len,
        input logic [7:0] b0,
        input logic [7:0] b1,
        input logic [7:0] b2,
        input logic [7:0] b3
    );
        logic [CP_W-1:0] cp;
        if (len == LEN_2)
            cp = {10'd0, b0[4:0], b1[5:0]};
        else if (len == LEN_3)
            cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
        else
            cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
        return cp;
    endfunction

    // Re-decode up to three buffered bytes that precede the terminator.
    function automatic run_t decode_run(
        input logic [1:0]      n,
        input logic [2:0][7:0] bytes
    );
        run_t       r;
        logic [7:0] ext [0:4];
        logic [2:0] pos;
        logic [2:0] len;
        logic [3:0] span;
        ext[0] = bytes[0];
        ext[1] = bytes[1];
        ext[2] = bytes[2];
        ext[3] = 8'd0;
        ext[4] = 8'd0;
        pos    = 3'd0;
        r.cnt  = 2'd0;
        r.cp   = '0;
        for (int k = 0; k < 3; k++)
        begin
            if (pos < {1'b0, n})
            begin
                len  = seq_len(ext[pos]);
                span = {1'b0, pos} + {1'b0, len};
                if (len >= LEN_2 && span <= {2'b00, n})
                begin
                    r.cp[k] = combine(len, ext[pos], ext[pos + 3'd1],
                                      ext[pos + 3'd2], 8'd0);
                    pos     = span[2:0];
                end
                else
                begin
                    r.cp[k] = {13'd0, ext[pos]};
                    pos     = pos + 3'd1;
                end
                r.cnt = r.cnt + 2'd1;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/lu8dec_front.sv =====
// Front part: accepts bytes, tracks the pending sequence and issues jobs.
// Depends on lu8dec_pkg.
`default_nettype none

module lu8dec_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         byte_in,
    output logic                    push,
    output lu8dec_pkg::job_t        job,
    input  wire logic               queue_full
);

    logic [2:0][7:0] pend_reg;
    logic [2:0][7:0] pend_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            fire;
    logic [2:0]      lead_len;
    logic [2:0]      in_len;
    logic [2:0]      cnt_plus;
    logic [7:0]      s1;
    logic [7:0]      s2;

    assign in_ready = !queue_full;
    assign fire     = in_valid && in_ready;
    assign in_len   = lu8dec_pkg::seq_len(byte_in);
    assign lead_len = lu8dec_pkg::seq_len(pend_reg[0]) < lu8dec_pkg::LEN_2 ?
                      lu8dec_pkg::LEN_2 : lu8dec_pkg::seq_len(pend_reg[0]);
    assign cnt_plus = {1'b0, count_reg} + 3'd1;
    assign s1       = (count_reg == 2'd1) ? byte_in : pend_reg[1];
    assign s2       = (count_reg == 2'd2) ? byte_in : pend_reg[2];

    always_comb
    begin
        pend_next   = pend_reg;
        count_next  = count_reg;
        push        = 1'b0;
        job.kind    = lu8dec_pkg::JOB_CP;
        job.cp      = {13'd0, byte_in};
        job.n_bytes = count_reg;
        job.bytes   = pend_reg;
        if (fire)
        begin
            if (count_reg == 2'd0)
            begin
                if (byte_in != 8'd0)
                begin
                    if (in_len <= lu8dec_pkg::LEN_1)
                        push = 1'b1;     // ASCII or stray byte, raw
                    else
                    begin
                        pend_next[0] = byte_in;
                        count_next   = 2'd1;
                    end
                end
            end
            else if (byte_in == 8'd0)
            begin
                push       = 1'b1;       // truncated: hand buffer to back part
                job.kind   = lu8dec_pkg::JOB_FLUSH;
                count_next = 2'd0;
            end
            else if (cnt_plus >= lead_len)
            begin
                push       = 1'b1;
                job.cp     = lu8dec_pkg::combine(lead_len, pend_reg[0], s1, s2, byte_in);
                count_next = 2'd0;
            end
            else
            begin
                pend_next[count_reg] = byte_in;
                count_next           = cnt_plus[1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

endmodule

`default_nettype wire

// ===== src/lu8dec_queue.sv =====
// Two-entry job queue between the front and back parts.
// Depends on lu8dec_pkg.
`default_nettype none

module lu8dec_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire lu8dec_pkg::job_t   push_job,
    output logic                    full,
    output logic                    not_empty,
    input  wire logic               pop,
    output lu8dec_pkg::job_t        head
);

    lu8dec_pkg::job_t mem_reg [0:1];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       fill_reg;
    logic [1:0]       fill_next;
    logic             do_pop;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = push   ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

// ===== src/lu8dec_back.sv =====
// Back part: expands the head job into one to three results.
// Depends on lu8dec_pkg.
`default_nettype none

module lu8dec_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          job_valid,
    input  wire lu8dec_pkg::job_t              job,
    output logic                               pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [lu8dec_pkg::CP_W-1:0]        code_point,
    output logic                               last_of_run
);

    lu8dec_pkg::run_t run;
    logic [1:0]       idx_reg;
    logic [1:0]       idx_next;
    logic             fire;

    always_comb
    begin
        unique case (job.kind)
            lu8dec_pkg::JOB_CP:
            begin
                run.cnt   = 2'd1;
                run.cp    = '0;
                run.cp[0] = job.cp;
            end
            lu8dec_pkg::JOB_FLUSH:
                run = lu8dec_pkg::decode_run(job.n_bytes, job.bytes);
            default:
                run = '0;
        endcase
    end

    assign out_valid   = job_valid;
    assign code_point  = run.cp[idx_reg];
    assign last_of_run = (idx_reg == run.cnt - 2'd1);
    assign fire        = out_valid && out_ready;
    assign pop         = fire && last_of_run;
    assign idx_next    = fire ? (last_of_run ? 2'd0 : idx_reg + 2'd1) : idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 2'd0;
        else
            idx_reg <= idx_next;
    end

endmodule

`default_nettype wire

// ===== src/lenient_utf8_decoder_core.sv =====
// Top level of the lenient UTF-8 decoder: front, job queue and back part.
// Depends on lu8dec_pkg, lu8dec_front, lu8dec_queue and lu8dec_back.
//
// Streaming UTF-8 decoder that takes one byte per transaction and returns
// code points. ASCII and stray bytes come out raw; 2-, 3- and 4-byte leads
// collect the following non-zero bytes (low six bits used, no overlong or
// surrogate checks). A zero byte ends the string: with a sequence pending,
// the lead comes out raw and the buffered bytes are decoded again as new
// leads, giving up to three results; last_of_run marks the final result of
// each input byte that yields results. Throughput is one byte per cycle
// while the job queue is not full; a flush holds the output for up to three
// results and the two-entry job queue absorbs the difference before input
// ready drops. Each result is held in the queue register between acceptance
// and output. The front part decides per byte whether it completes, extends
// or flushes a sequence; the back part walks the flush results.
`default_nettype none

module lenient_utf8_decoder_core (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // byte channel
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [7:0]                byte_in,
    // result channel
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [lu8dec_pkg::CP_W-1:0]    code_point,
    output logic                           last_of_run
);

    lu8dec_pkg::job_t new_job;
    lu8dec_pkg::job_t head_job;
    logic             push;
    logic             pop;
    logic             queue_full;
    logic             queue_not_empty;

    // front: pending sequence state, one job per byte that yields results
    lu8dec_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_in    (byte_in),
        .push       (push),
        .job        (new_job),
        .queue_full (queue_full)
    );

    // queue decouples byte intake from multi-result output
    lu8dec_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (new_job),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .pop       (pop),
        .head      (head_job)
    );

    // back: one result per output transaction, pops on the last one
    lu8dec_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (queue_not_empty),
        .job         (head_job),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .code_point  (code_point),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire
